[hdl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants, codes and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY       = 16;
    localparam int PRIORITY_WIDTH = 8;
    localparam int TAG_WIDTH      = 8;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int ENTRY_W = PRIORITY_WIDTH + TAG_WIDTH;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [PRIORITY_WIDTH-1:0] prio;
        logic [TAG_WIDTH-1:0]      tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_LAST,
        S_POP_HEAD,
        S_POP_MV,
        S_OUT
    } t_state;

endpackage

[hdl/spq_ram.sv]
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module spq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a RAM, highest priority at slot 0.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) carries one command per beat:
// i_mode selects insert or pop; inserts carry i_new_priority and i_new_tag.
// Every command returns exactly one beat on the output channel
// (o_out_valid / i_out_ready) with a status, the popped entry (zero for
// inserts and failures) and the entry count after the command.
// Entries of equal priority leave in arrival order.
// Commands are processed one at a time. A sequencer walks the RAM one slot
// per cycle with a single comparator: an insert scans up from the tail and
// moves each lower-priority entry down one slot; a pop reads the head and
// then moves the remaining entries up. A pop on an empty queue and an insert
// into an empty or full queue skip the walk. Every command ends in the
// hand-over state, which loads the result into the output register, and the
// next command is accepted at the earliest at the first edge at which that
// result can be taken. The walk is paced by the single RAM write port.
// Reset empties the queue at once; RAM contents are not cleared. A stalled
// receiver holds the result in the output register; a new command can be
// accepted meanwhile, and its result waits until that register frees up.
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [PRIORITY_WIDTH-1:0] i_new_priority,
    input  logic [TAG_WIDTH-1:0]      i_new_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_status,
    output logic [PRIORITY_WIDTH-1:0] o_out_priority,
    output logic [TAG_WIDTH-1:0]      o_out_tag,
    output logic [CNT_W-1:0]          o_entry_count
);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_idx, n_idx;
    t_entry                    r_new, n_new;
    logic [1:0]                r_res_status, n_res_status;
    t_entry                    r_res, n_res;

    logic                      r_out_valid, n_out_valid;
    logic [1:0]                r_out_status, n_out_status;
    t_entry                    r_out, n_out;
    logic [CNT_W-1:0]          r_out_count, n_out_count;

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    t_entry                    wr_data;
    logic [ADDR_W-1:0]         rd_addr;
    t_entry                    rd_data;
    logic [CNT_W-1:0]          idx_m1;
    logic [CNT_W-1:0]          idx_m2;
    logic [CNT_W-1:0]          idx_p1;
    logic [CNT_W-1:0]          idx_p2;
    logic                      in_fire;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign idx_m1 = r_idx - CNT_W'(1);
    assign idx_m2 = r_idx - CNT_W'(2);
    assign idx_p1 = r_idx + CNT_W'(1);
    assign idx_p2 = r_idx + CNT_W'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out        <= n_out;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out        = r_out;
        n_out_count  = r_out_count;
        wr_en        = 1'b0;
        wr_addr      = r_idx[ADDR_W-1:0];
        wr_data      = r_new;
        rd_addr      = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_new.prio   = i_new_priority;
                    n_new.tag    = i_new_tag;
                    n_res_status = STAT_OK;
                    n_res        = '0;
                    if (i_mode == MODE_POP) begin
                        if (r_count == '0) begin
                            n_res_status = STAT_EMPTY;
                            n_state      = S_OUT;
                        end else begin
                            rd_addr = '0;
                            n_state = S_POP_HEAD;
                        end
                    end else if (r_count == CAP_CNT) begin
                        n_res_status = STAT_FULL;
                        n_state      = S_OUT;
                    end else if (r_count == '0) begin
                        wr_en        = 1'b1;
                        wr_addr      = '0;
                        wr_data.prio = i_new_priority;
                        wr_data.tag  = i_new_tag;
                        n_count      = r_count + CNT_W'(1);
                        n_state      = S_OUT;
                    end else begin
                        // Start at the tail; the slot just past it is free.
                        n_idx   = r_count;
                        rd_addr = ADDR_W'(r_count - CNT_W'(1));
                        n_state = S_INS_CMP;
                    end
                end
            end

            S_INS_CMP: begin
                // rd_data holds the entry at r_idx - 1.
                if (rd_data.prio < r_new.prio) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    n_idx   = idx_m1;
                    if (r_idx == CNT_W'(1)) begin
                        n_state = S_INS_LAST;
                    end else begin
                        rd_addr = idx_m2[ADDR_W-1:0];
                    end
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_OUT;
                end
            end

            S_INS_LAST: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                n_count = r_count + CNT_W'(1);
                n_state = S_OUT;
            end

            S_POP_HEAD: begin
                n_res = rd_data;
                n_idx = '0;
                if (r_count > CNT_W'(1)) begin
                    rd_addr = ADDR_W'(1);
                    n_state = S_POP_MV;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_OUT;
                end
            end

            S_POP_MV: begin
                // rd_data holds the entry at r_idx + 1; move it up one slot.
                wr_en   = 1'b1;
                wr_data = rd_data;
                n_idx   = idx_p1;
                if (idx_p2 < r_count) begin
                    rd_addr = idx_p2[ADDR_W-1:0];
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out        = r_res;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_priority = r_out.prio;
    assign o_out_tag      = r_out.tag;
    assign o_entry_count  = r_out_count;

    // The queue never holds more than its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count above capacity");

    // The count moves by at most one per command.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count))) |->
            ((r_count == $past(r_count) + CNT_W'(1)) ||
             (r_count == $past(r_count) - CNT_W'(1))))
        else $error("entry count jumped");

    // A result appears only when the sequencer hands it over.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside hand-over");

    // A full queue never takes a write past its last slot.
    a_full_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS_CMP) |-> (r_count < CAP_CNT))
        else $error("insert scan on a full queue");

endmodule
